/* sv/bpsv_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsv_pkg: shared types and constants of the strip vote block
// Payload structs, configuration struct, register indexes and tally limits.
// ----------------------------------------------------------------------------
package bpsv_pkg;

  // Frame geometry defaults
  localparam int unsigned FRAME_WIDTH_DEF  = 640;
  localparam int unsigned FRAME_HEIGHT_DEF = 480;
  localparam int unsigned MAX_SECTIONS_DEF = 8;

  // Field widths
  localparam int unsigned PIX_W    = 8;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned STRIP_W  = 3;
  localparam int unsigned TALLY_W  = 20;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  // Register reset values
  localparam logic [2:0] BIT_SELECT_RST    = 3'd3;
  localparam logic [3:0] SECTION_COUNT_RST = 4'd8;
  localparam logic [9:0] SECTION_WIDTH_RST = 10'd80;
  localparam logic [8:0] REGION_ROWS_RST   = 9'd240;

  // Saturation limits of a strip tally
  localparam logic signed [TALLY_W-1:0] TALLY_MAX = 20'sh7FFFF;
  localparam logic signed [TALLY_W-1:0] TALLY_MIN = 20'sh80000;

  localparam logic [PIX_W-1:0] PIX_BRIGHT = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_DARK   = 8'h00;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BIT_SELECT    = 3'd0,
    REG_SECTION_COUNT = 3'd1,
    REG_SECTION_WIDTH = 3'd2,
    REG_REGION_ROWS   = 3'd3
  } bpsv_reg_e;

  typedef struct packed {
    logic [2:0] bit_select;
    logic [3:0] section_count;
    logic [9:0] section_width;
    logic [8:0] region_rows;
  } bpsv_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_value;
    logic             frame_last;
  } bpsv_in_t;

  typedef struct packed {
    logic [PIX_W-1:0]  plane_pixel;
    logic              code_valid;
    logic [CODE_W-1:0] code_value;
  } bpsv_out_t;

  // Classified pixel handed from front to back
  typedef struct packed {
    logic               bright;
    logic               vote;
    logic [STRIP_W-1:0] strip;
    logic               last;
    logic [CODE_W-1:0]  mask;
  } bpsv_cmd_t;

endpackage

/* sv/bpsv_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsv_front: pixel intake and classification
// Tracks raster position, finds the strip of each pixel and decides its vote.
// ----------------------------------------------------------------------------
module bpsv_front import bpsv_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bpsv_cfg_t cfg_i,
  input  logic      in_valid_i,
  input  bpsv_in_t  in_data_i,
  output logic      in_stall_o,
  output logic      cmd_valid_o,
  output bpsv_cmd_t cmd_o,
  input  logic      cmd_full_i
);

  localparam int unsigned COL_W = $clog2(FRAME_WIDTH);
  localparam int unsigned ROW_W = $clog2(FRAME_HEIGHT + 1);

  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] row_q, row_d;
  logic             accept;
  logic [3:0]       n_live;
  logic [13:0]      span;
  logic             row_ok;
  logic             col_ok;
  logic [STRIP_W-1:0] strip;
  logic [CODE_W-1:0]  mask;

  assign in_stall_o  = cmd_full_i;
  assign accept      = in_valid_i & ~cmd_full_i;
  assign cmd_valid_o = accept;

  // Classify the pixel at the current raster position
  always_comb begin
    n_live = (cfg_i.section_count > 4'(MAX_SECTIONS)) ? 4'(MAX_SECTIONS)
                                                       : cfg_i.section_count;
    span   = 14'(n_live) * 14'(cfg_i.section_width);
    row_ok = (32'(row_q) < 32'(FRAME_HEIGHT)) && (32'(row_q) < 32'(cfg_i.region_rows));
    col_ok = 32'(col_q) < 32'(span);
    // strip is the last boundary passed; boundaries rise with their index
    strip  = '0;
    for (int unsigned k = 1; k < MAX_SECTIONS; k++) begin
      if (32'(col_q) >= 32'(k) * 32'(cfg_i.section_width)) begin
        strip = STRIP_W'(k);
      end
    end
    mask = '0;
    for (int unsigned k = 0; k < CODE_W; k++) begin
      mask[k] = 4'(k) < n_live;
    end
    cmd_o.bright = in_data_i.pixel_value[cfg_i.bit_select];
    cmd_o.vote   = (cfg_i.section_width != '0) && row_ok && col_ok;
    cmd_o.strip  = strip;
    cmd_o.last   = in_data_i.frame_last;
    cmd_o.mask   = mask;
  end

  // Advance the raster position; clear it after the last pixel
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (in_data_i.frame_last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_q == COL_W'(FRAME_WIDTH - 1)) begin
        col_d = '0;
        if (row_q != ROW_W'(FRAME_HEIGHT)) begin
          row_d = row_q + ROW_W'(1);
        end
      end else begin
        col_d = col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

/* sv/bpsv_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsv_queue: two-entry queue between front and back
// Lets the front keep taking pixels while the back waits on the output.
// ----------------------------------------------------------------------------
module bpsv_queue import bpsv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  bpsv_cmd_t data_i,
  output logic      full_o,
  output logic      valid_o,
  output bpsv_cmd_t data_o,
  input  logic      pop_i
);

  bpsv_cmd_t  mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = cnt_q == 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign data_o  = mem_q[rd_q];

  // Store the incoming word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  // Move the pointers and the fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) begin
        wr_q <= ~wr_q;
      end
      if (pop_i) begin
        rd_q <= ~rd_q;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* sv/bpsv_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpsv_back: strip tallies and result register
// Applies each vote to its strip tally and forms the code on the last pixel.
// ----------------------------------------------------------------------------
module bpsv_back import bpsv_pkg::*; #(
  parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  input  bpsv_cmd_t cmd_i,
  output logic      cmd_pop_o,
  output logic      out_valid_o,
  output bpsv_out_t out_data_o,
  input  logic      out_stall_i
);

  logic signed [TALLY_W-1:0] tally_q  [MAX_SECTIONS];
  logic signed [TALLY_W-1:0] tally_nx [MAX_SECTIONS];
  logic              out_valid_q;
  bpsv_out_t         out_data_q;
  logic              load;
  logic [CODE_W-1:0] code;

  assign load        = ~out_valid_q | ~out_stall_i;
  assign cmd_pop_o   = cmd_valid_i & load;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Vote into the hit strip with saturation, then read the signs
  always_comb begin
    code = '0;
    for (int unsigned k = 0; k < MAX_SECTIONS; k++) begin
      tally_nx[k] = tally_q[k];
      if (cmd_i.vote && cmd_i.strip == STRIP_W'(k)) begin
        if (cmd_i.bright) begin
          if (tally_q[k] != TALLY_MAX) begin
            tally_nx[k] = tally_q[k] + 20'sd1;
          end
        end else begin
          if (tally_q[k] != TALLY_MIN) begin
            tally_nx[k] = tally_q[k] - 20'sd1;
          end
        end
      end
      code[k] = cmd_i.mask[k] & tally_nx[k][TALLY_W-1];
    end
  end

  // Hold tallies; clear them after the last pixel of a frame
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int unsigned k = 0; k < MAX_SECTIONS; k++) begin
        tally_q[k] <= '0;
      end
    end else if (cmd_pop_o) begin
      for (int unsigned k = 0; k < MAX_SECTIONS; k++) begin
        tally_q[k] <= cmd_i.last ? '0 : tally_nx[k];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= cmd_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      out_data_q.plane_pixel <= cmd_i.bright ? PIX_BRIGHT : PIX_DARK;
      out_data_q.code_valid  <= cmd_i.last;
      out_data_q.code_value  <= cmd_i.last ? code : '0;
    end
  end

endmodule

/* sv/bit_plane_strip_vote.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_plane_strip_vote: bit-plane pixel stream with per-strip dark/bright vote
// Top level: configuration registers, front, queue and back.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock while in_stall_o is low and returns one word
// per pixel, in order, via the front/back queue, then the result register.
// The strip tally update is a single saturating add per pixel, so the block
// sustains one pixel per clock while the output is not stalled. A two-entry
// queue parts intake from the tallies and a result register parts the tallies
// from the output, so in_stall_o rises only once the queue is full.
// Configuration writes are always taken (cfg_ready_o is high) and act on the
// next accepted pixel; write them only between pixels with no result pending.
// The code word appears on the result of the pixel marked frame_last.
module bit_plane_strip_vote import bpsv_pkg::*; #(
  parameter int unsigned FRAME_WIDTH  = FRAME_WIDTH_DEF,
  parameter int unsigned FRAME_HEIGHT = FRAME_HEIGHT_DEF,
  parameter int unsigned MAX_SECTIONS = MAX_SECTIONS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  bpsv_in_t              in_data_i,
  output logic                  in_stall_o,
  output logic                  out_valid_o,
  output bpsv_out_t             out_data_o,
  input  logic                  out_stall_i,
  input  logic                  cfg_valid_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  cfg_ready_o
);

  bpsv_cfg_t cfg_q;
  logic      cmd_push, cmd_full, cmd_valid, cmd_pop;
  bpsv_cmd_t cmd_in, cmd_out;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bit_select    <= BIT_SELECT_RST;
      cfg_q.section_count <= SECTION_COUNT_RST;
      cfg_q.section_width <= SECTION_WIDTH_RST;
      cfg_q.region_rows   <= REGION_ROWS_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BIT_SELECT:    cfg_q.bit_select    <= cfg_data_i[2:0];
        REG_SECTION_COUNT: cfg_q.section_count <= cfg_data_i[3:0];
        REG_SECTION_WIDTH: cfg_q.section_width <= cfg_data_i[9:0];
        REG_REGION_ROWS:   cfg_q.region_rows   <= cfg_data_i[8:0];
        default: ;
      endcase
    end
  end

  bpsv_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT),
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_data_i   (in_data_i),
    .in_stall_o  (in_stall_o),
    .cmd_valid_o (cmd_push),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  bpsv_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .valid_o (cmd_valid),
    .data_o  (cmd_out),
    .pop_i   (cmd_pop)
  );

  bpsv_back #(
    .MAX_SECTIONS (MAX_SECTIONS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
